// ===== src/gb5_pkg.sv =====
`default_nettype none
package gb5_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int MIN_SIZE     = 5;

   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // kernel geometry
   localparam int WIN        = 5;
   localparam int TAPS       = WIN - 1;
   localparam int WIN_MARGIN = WIN - 1;
   localparam int LINE_W     = TAPS * PIX_W;
   localparam int VSUM_W     = PIX_W + 4;
   localparam int HSUM_W     = VSUM_W + 4;

   // front to back queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [WIN-1:0][PIX_W-1:0] rows;   // index 0 is the oldest row
      logic                      emit;
      logic                      frame_end;
   } col_beat_type;

endpackage
`default_nettype wire

// ===== src/gb5_queue.sv =====
`default_nettype none
module gb5_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  wire gb5_pkg::col_beat_type  push_beat,
   input  wire                         pop,
   output logic                        q_valid,
   output gb5_pkg::col_beat_type       q_beat,
   output logic [gb5_pkg::QCNT_W-1:0]  q_count
);

   gb5_pkg::col_beat_type              slots_ff [gb5_pkg::QDEPTH];
   logic [gb5_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [gb5_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [gb5_pkg::QCNT_W-1:0]         count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? gb5_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? gb5_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = gb5_pkg::QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = gb5_pkg::QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_beat;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_beat  = slots_ff[rd_ptr_ff];
   assign q_count = count_ff;

endmodule
`default_nettype wire

// ===== src/gb5_front.sv =====
`default_nettype none
module gb5_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [gb5_pkg::PIX_W-1:0]        req_tdata,
   input  wire                              req_tuser,
   input  wire                              csr_we,
   input  wire  [gb5_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [gb5_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire  [gb5_pkg::QCNT_W-1:0]       q_count,
   output logic                             push,
   output gb5_pkg::col_beat_type            push_beat
);

   function automatic logic [gb5_pkg::COL_W-1:0] width_last(
      input logic [gb5_pkg::WIDTH_REG_W-1:0] v);
      int c;
      c = int'(v);
      if (c < gb5_pkg::MIN_SIZE) begin
         c = gb5_pkg::MIN_SIZE;
      end else if (c > gb5_pkg::MAX_WIDTH) begin
         c = gb5_pkg::MAX_WIDTH;
      end
      return gb5_pkg::COL_W'(c - 1);
   endfunction

   function automatic logic [gb5_pkg::ROW_W-1:0] height_last(
      input logic [gb5_pkg::HEIGHT_REG_W-1:0] v);
      int c;
      c = int'(v);
      if (c < gb5_pkg::MIN_SIZE) begin
         c = gb5_pkg::MIN_SIZE;
      end else if (c > gb5_pkg::MAX_HEIGHT) begin
         c = gb5_pkg::MAX_HEIGHT;
      end
      return gb5_pkg::ROW_W'(c - 1);
   endfunction

   logic [gb5_pkg::LINE_W-1:0]  line_mem [gb5_pkg::MAX_WIDTH];

   logic [gb5_pkg::COL_W-1:0]   col_ff, col_in;
   logic [gb5_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [gb5_pkg::COL_W-1:0]   wlast_ff, wlast_in;
   logic [gb5_pkg::ROW_W-1:0]   hlast_ff, hlast_in;

   // read stage of the line store
   logic                        valid1_ff, valid1_in;
   logic [gb5_pkg::COL_W-1:0]   addr1_ff, addr1_in;
   logic [gb5_pkg::PIX_W-1:0]   pix1_ff, pix1_in;
   logic                        emit1_ff, emit1_in;
   logic                        fe1_ff, fe1_in;
   logic [gb5_pkg::LINE_W-1:0]  rd_ff;
   logic                        hit_ff, hit_in;
   logic [gb5_pkg::LINE_W-1:0]  hit_word_ff, hit_word_in;

   logic                        accept;
   logic [gb5_pkg::COL_W-1:0]   col_cur;
   logic [gb5_pkg::ROW_W-1:0]   row_cur;
   logic                        last_col, last_row;
   logic [gb5_pkg::LINE_W-1:0]  word1, new_word;

   assign req_tready = (int'(q_count) + int'(valid1_ff)) < gb5_pkg::QDEPTH;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_cur  = req_tuser ? '0 : col_ff;
      row_cur  = req_tuser ? '0 : row_ff;
      last_col = (col_cur >= wlast_ff);
      last_row = (row_cur >= hlast_ff);

      // same column written at the edge this word was read
      word1    = hit_ff ? hit_word_ff : rd_ff;
      new_word = {word1[gb5_pkg::LINE_W-gb5_pkg::PIX_W-1:0], pix1_ff};

      col_in      = col_ff;
      row_in      = row_ff;
      valid1_in   = accept;
      addr1_in    = col_cur;
      pix1_in     = req_tdata;
      emit1_in    = (col_cur >= gb5_pkg::COL_W'(gb5_pkg::WIN_MARGIN))
                 && (row_cur >= gb5_pkg::ROW_W'(gb5_pkg::WIN_MARGIN));
      fe1_in      = last_col && last_row;
      hit_in      = accept && valid1_ff && (col_cur == addr1_ff);
      hit_word_in = new_word;

      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : gb5_pkg::ROW_W'(row_cur + 1'b1);
         end else begin
            col_in = gb5_pkg::COL_W'(col_cur + 1'b1);
            row_in = row_cur;
         end
      end

      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      if (csr_we) begin
         case (csr_index)
            gb5_pkg::CSR_LINE_WIDTH: begin
               wlast_in = width_last(csr_wdata[gb5_pkg::WIDTH_REG_W-1:0]);
            end
            gb5_pkg::CSR_FRAME_HEIGHT: begin
               hlast_in = height_last(csr_wdata[gb5_pkg::HEIGHT_REG_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         wlast_ff  <= width_last(gb5_pkg::WIDTH_REG_W'(512));
         hlast_ff  <= height_last(gb5_pkg::HEIGHT_REG_W'(512));
         valid1_ff <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         wlast_ff  <= wlast_in;
         hlast_ff  <= hlast_in;
         valid1_ff <= valid1_in;
         hit_ff    <= hit_in;
      end
      addr1_ff    <= addr1_in;
      pix1_ff     <= pix1_in;
      emit1_ff    <= emit1_in;
      fe1_ff      <= fe1_in;
      hit_word_ff <= hit_word_in;
   end

   // line store: four previous rows per column, oldest in the top byte
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (valid1_ff) begin
         line_mem[addr1_ff] <= new_word;
      end
   end

   always_comb begin
      push_beat.emit      = emit1_ff;
      push_beat.frame_end = fe1_ff;
      for (int r = 0; r < gb5_pkg::TAPS; r++) begin
         push_beat.rows[r] = word1[gb5_pkg::LINE_W-1-r*gb5_pkg::PIX_W -: gb5_pkg::PIX_W];
      end
      push_beat.rows[gb5_pkg::TAPS] = pix1_ff;
   end

   assign push = valid1_ff;

endmodule
`default_nettype wire

// ===== src/gb5_back.sv =====
`default_nettype none
module gb5_back (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             q_valid,
   input  wire gb5_pkg::col_beat_type      q_beat,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [gb5_pkg::PIX_W-1:0]       rsp_tdata,
   output logic                            rsp_tlast
);

   logic [gb5_pkg::WIN-1:0][gb5_pkg::VSUM_W-1:0] vwin_ff, vwin_in;
   logic                                         s1_valid_ff, s1_valid_in;
   logic                                         s1_fe_ff, s1_fe_in;
   logic                                         rsp_valid_ff, rsp_valid_in;
   logic [gb5_pkg::PIX_W-1:0]                    rsp_data_ff, rsp_data_in;
   logic                                         rsp_last_ff, rsp_last_in;

   logic                                         s1_move;
   logic [gb5_pkg::VSUM_W-1:0]                   vsum;
   logic [gb5_pkg::HSUM_W-1:0]                   hsum;

   assign s1_move = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign pop     = q_valid && (!s1_valid_ff || s1_move);

   always_comb begin
      // vertical 1,4,6,4,1 over the new column
      vsum = gb5_pkg::VSUM_W'(q_beat.rows[0])
           + gb5_pkg::VSUM_W'(q_beat.rows[4])
           + ((gb5_pkg::VSUM_W'(q_beat.rows[1]) + gb5_pkg::VSUM_W'(q_beat.rows[3])) << 2)
           + (gb5_pkg::VSUM_W'(q_beat.rows[2]) << 2)
           + (gb5_pkg::VSUM_W'(q_beat.rows[2]) << 1);

      // horizontal 1,4,6,4,1 over the column sums
      hsum = gb5_pkg::HSUM_W'(vwin_ff[0])
           + gb5_pkg::HSUM_W'(vwin_ff[4])
           + ((gb5_pkg::HSUM_W'(vwin_ff[1]) + gb5_pkg::HSUM_W'(vwin_ff[3])) << 2)
           + (gb5_pkg::HSUM_W'(vwin_ff[2]) << 2)
           + (gb5_pkg::HSUM_W'(vwin_ff[2]) << 1);

      vwin_in     = vwin_ff;
      s1_valid_in = s1_valid_ff;
      s1_fe_in    = s1_fe_ff;
      if (pop) begin
         for (int i = 0; i < gb5_pkg::WIN - 1; i++) begin
            vwin_in[i] = vwin_ff[i+1];
         end
         vwin_in[gb5_pkg::WIN-1] = vsum;
         s1_valid_in = q_beat.emit;
         s1_fe_in    = q_beat.frame_end;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = hsum[gb5_pkg::HSUM_W-1 -: gb5_pkg::PIX_W];
         rsp_last_in  = s1_fe_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vwin_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vwin_ff      <= vwin_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_fe_ff    <= s1_fe_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== src/gaussian_blur_5x5_top.sv =====
`default_nettype none
// 5x5 binomial gaussian blur (1,4,6,4,1 outer product, sum 256) on 8-bit
// grayscale pixels in raster order. while the output is not stalled, one
// pixel beat per clock is taken and one result beat per clock is given;
// rsp_tvalid rises once the pixel completing its window has passed the front
// read stage, queue, window stage and output register. only centre
// pixels two or more pixels from every frame edge give a result, which is
// the full precision sum divided by 256 and floored; rsp_tlast marks the
// last result of a frame. req_tuser high marks the first pixel of a frame.
// the rate is set by the line store, a 2048 x 32-bit memory read and written
// once per pixel. line_width (index 0) and frame_height (index 1) are
// saturated to [5, 2048] and [5, 4096] and may be written only while idle.
module gaussian_blur_5x5_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [7:0]                       req_tdata,   // pixel
   input  wire                              req_tuser,   // frame_start
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [7:0]                       rsp_tdata,   // blurred
   output logic                             rsp_tlast,
   input  wire                              csr_we,
   input  wire  [gb5_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [gb5_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                           push;
   gb5_pkg::col_beat_type          push_beat;
   logic                           pop;
   logic                           q_valid;
   gb5_pkg::col_beat_type          q_beat;
   logic [gb5_pkg::QCNT_W-1:0]     q_count;

   gb5_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .push       (push),
      .push_beat  (push_beat)
   );

   gb5_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_beat    (q_beat),
      .q_count   (q_count)
   );

   gb5_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_beat     (q_beat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== tb/gaussian_blur_5x5_checker.sv =====
`timescale 1ns / 100ps
module gaussian_blur_5x5_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire  [7:0]                        req_tdata,   // pixel
   input  wire                               req_tuser,   // frame_start
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire  [7:0]                        rsp_tdata,   // blurred
   input  wire                               rsp_tlast,
   input  wire                               csr_we,
   input  wire  [gb5_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [gb5_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                fail_count,
   output int                                pending_results
);

   // binomial taps 1,4,6,4,1, four bits each
   localparam logic [19:0] BINOM = {4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

   typedef struct packed {
      logic [gb5_pkg::PIX_W-1:0] blurred;
      logic                      frame_end;
   } blur_result_type;

   blur_result_type                   blurred_q[$];
   logic [31:0]                       line_store [gb5_pkg::MAX_WIDTH];
   logic [gb5_pkg::PIX_W-1:0]         win [5][5];
   int unsigned                       col_cnt = 0;
   int unsigned                       row_cnt = 0;
   logic [gb5_pkg::WIDTH_REG_W-1:0]   line_width = 12'd512;
   logic [gb5_pkg::HEIGHT_REG_W-1:0]  frame_height = 13'd512;
   int                                errors = 0;

   function automatic void blur_pixel(input logic [7:0] pix, input logic first);
      int unsigned               w;
      int unsigned               h;
      int unsigned               sum;
      logic [31:0]               word;
      logic [gb5_pkg::PIX_W-1:0] fresh [5];
      logic                      last_col;
      logic                      last_row;
      blur_result_type           res;
      w = (line_width < gb5_pkg::MIN_SIZE) ? gb5_pkg::MIN_SIZE :
          (line_width > gb5_pkg::MAX_WIDTH) ? gb5_pkg::MAX_WIDTH : line_width;
      h = (frame_height < gb5_pkg::MIN_SIZE) ? gb5_pkg::MIN_SIZE :
          (frame_height > gb5_pkg::MAX_HEIGHT) ? gb5_pkg::MAX_HEIGHT : frame_height;
      if (first) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      // oldest row sits in the top byte of each column word
      word = line_store[col_cnt];
      for (int r = 0; r < 4; r++)
         fresh[r] = word[24 - 8 * r +: 8];
      fresh[4] = pix;
      line_store[col_cnt] = {word[23:0], pix};
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 4; c++)
            win[r][c] = win[r][c + 1];
         win[r][4] = fresh[r];
      end
      last_col = (col_cnt >= w - 1);
      last_row = (row_cnt >= h - 1);
      if (row_cnt >= 4 && col_cnt >= 4) begin
         sum = 0;
         for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
               sum += BINOM[4 * r +: 4] * BINOM[4 * c +: 4] * win[r][c];
         res.blurred   = 8'(sum >> 8);
         res.frame_end = last_col && last_row;
         blurred_q.push_back(res);
      end
      if (last_col) begin
         col_cnt = 0;
         row_cnt = last_row ? 0 : row_cnt + 1;
      end else begin
         col_cnt++;
      end
   endfunction

   always @(posedge clock) begin
      blur_result_type want;
      if (reset) begin
         blurred_q.delete();
         foreach (line_store[i])
            line_store[i] = '0;
         foreach (win[r, c])
            win[r][c] = '0;
         col_cnt      = 0;
         row_cnt      = 0;
         line_width   = 12'd512;
         frame_height = 13'd512;
      end else begin
         if (csr_we) begin
            case (csr_index)
               gb5_pkg::CSR_LINE_WIDTH: begin
                  line_width = csr_wdata[gb5_pkg::WIDTH_REG_W-1:0];
               end
               gb5_pkg::CSR_FRAME_HEIGHT: begin
                  frame_height = csr_wdata[gb5_pkg::HEIGHT_REG_W-1:0];
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            blur_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (blurred_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result beat with nothing pending: blurred %0d last %0b",
                           $realtime, rsp_tdata, rsp_tlast);
            end else begin
               want = blurred_q.pop_front();
               if (want.blurred !== rsp_tdata || want.frame_end !== rsp_tlast) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: blurred %0d last %0b expected, got %0d last %0b",
                              $realtime, want.blurred, want.frame_end, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
      fail_count      <= errors;
      pending_results <= blurred_q.size();
   end

endmodule

// ===== tb/gaussian_blur_5x5_top_tb.sv =====
`timescale 1ns / 100ps
module gaussian_blur_5x5_top_tb;

   typedef enum int {FRAME_CLEAN, FRAME_OVERRUN, FRAME_CUT, FRAME_RESTART} frame_kind_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = '0;   // pixel
   logic                             req_tuser = 1'b0; // frame_start
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [7:0]                       rsp_tdata;        // blurred
   logic                             rsp_tlast;
   logic                             csr_we = 1'b0;
   logic [gb5_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [gb5_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;
   int                               fail_count;
   int                               pending_results;
   int                               idle_pct = 0;
   int                               stall_pct = 0;
   bit                               aligned = 1'b0;

   gaussian_blur_5x5_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   gaussian_blur_5x5_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic write_reg(input logic [gb5_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [gb5_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [7:0] pix, input logic first);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic send_frames(input int unsigned w, input int unsigned h,
                              input int unsigned frames, input bit noisy);
      int unsigned    len;
      int unsigned    restart_at;
      int unsigned    roll;
      frame_kind_type kind;
      bit             lead;
      for (int unsigned f = 0; f < frames; f++) begin
         roll = noisy ? $urandom_range(19) : 19;
         kind = (roll == 0) ? FRAME_OVERRUN :
                (roll == 1) ? FRAME_CUT :
                (roll == 2) ? FRAME_RESTART : FRAME_CLEAN;
         len        = w * h;
         lead       = 1'b1;
         restart_at = len;
         case (kind)
            FRAME_OVERRUN: lead = !aligned;
            FRAME_CUT:     len = $urandom_range(len - 1, 1);
            FRAME_RESTART: restart_at = $urandom_range(len - 1, 1);
            default: ;
         endcase
         for (int unsigned i = 0; i < len; i++)
            send_pixel(8'($urandom), (i == 0 && lead) || i == restart_at);
         aligned = (kind == FRAME_CLEAN || kind == FRAME_OVERRUN);
      end
   endtask

   initial begin
      #6_000_000;
      $display("[gaussian_blur_5x5_top] ERROR");
      $finish;
   end

   initial begin
      int unsigned w;
      int unsigned h;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(gb5_pkg::CSR_LINE_WIDTH, 13'd5);
      write_reg(gb5_pkg::CSR_FRAME_HEIGHT, 13'd5);
      for (int i = 0; i < 25; i++) send_pixel(8'hFF, i == 0);
      for (int i = 0; i < 25; i++) send_pixel(8'h00, i == 0);
      for (int i = 0; i < 25; i++) send_pixel((i == 12) ? 8'hFF : 8'h00, i == 0);
      // overrun into a frame with no frame start
      for (int i = 0; i < 25; i++) send_pixel(8'($urandom), 1'b0);
      // frame start again in the middle of a frame
      for (int i = 0; i < 37; i++) send_pixel(8'($urandom), i == 0 || i == 12);

      // line narrowed while the column count is past the new end
      wait_idle();
      write_reg(gb5_pkg::CSR_LINE_WIDTH, 13'd8);
      write_reg(gb5_pkg::CSR_FRAME_HEIGHT, 13'd9);
      for (int i = 0; i < 47; i++) send_pixel(8'($urandom), i == 0);
      wait_idle();
      write_reg(gb5_pkg::CSR_LINE_WIDTH, 13'd5);
      for (int i = 0; i < 16; i++) send_pixel(8'($urandom), 1'b0);

      // saturation at both ends
      wait_idle();
      write_reg(gb5_pkg::CSR_LINE_WIDTH, 13'h1FFF);
      write_reg(gb5_pkg::CSR_FRAME_HEIGHT, 13'h1FFF);
      for (int i = 0; i < 40; i++) send_pixel(8'($urandom), i == 0);
      wait_idle();
      write_reg(gb5_pkg::CSR_LINE_WIDTH, '0);
      write_reg(gb5_pkg::CSR_FRAME_HEIGHT, '0);
      send_frames(5, 5, 2, 1'b0);

      for (int ph = 0; ph < 4; ph++) begin
         for (int k = 0; k < 2; k++) begin
            wait_idle();
            case (ph)
               0: begin idle_pct = 0;  stall_pct <= 0;  end
               1: begin idle_pct = 69; stall_pct <= 0;  end
               2: begin idle_pct = 0;  stall_pct <= 69; end
               default: begin idle_pct = 32; stall_pct <= 32; end
            endcase
            w = $urandom_range(12);
            h = $urandom_range(9);
            write_reg(gb5_pkg::CSR_LINE_WIDTH, gb5_pkg::CSR_DATA_W'(w));
            write_reg(gb5_pkg::CSR_FRAME_HEIGHT, gb5_pkg::CSR_DATA_W'(h));
            if (w < gb5_pkg::MIN_SIZE) w = gb5_pkg::MIN_SIZE;
            if (h < gb5_pkg::MIN_SIZE) h = gb5_pkg::MIN_SIZE;
            send_frames(w, h, 70 / (w * h) + 1, 1'b1);
         end
      end

      wait_idle();
      if (fail_count == 0)
         $display("[gaussian_blur_5x5_top] OK");
      else
         $display("[gaussian_blur_5x5_top] ERROR");
      $finish;
   end

endmodule

// ===== gaussian_blur_5x5_top.f =====
src/gb5_pkg.sv
src/gb5_queue.sv
src/gb5_front.sv
src/gb5_back.sv
src/gaussian_blur_5x5_top.sv
tb/gaussian_blur_5x5_checker.sv
tb/gaussian_blur_5x5_top_tb.sv
